### hw/rtl/arp_pkg.sv
// Shared types, codes and decode helpers for the AArch64 relocation patcher.
`timescale 1ns / 1ps
package arp_pkg;

  // Relocation kinds (input tuser)
  localparam logic [3:0] OP_BRANCH26  = 4'd0;
  localparam logic [3:0] OP_ADR_PAGE  = 4'd1;
  localparam logic [3:0] OP_GOT_PAGE  = 4'd2;
  localparam logic [3:0] OP_ADD_LO12  = 4'd3;
  localparam logic [3:0] OP_LDST8     = 4'd4;
  localparam logic [3:0] OP_LDST16    = 4'd5;
  localparam logic [3:0] OP_LDST32    = 4'd6;
  localparam logic [3:0] OP_LDST64    = 4'd7;
  localparam logic [3:0] OP_LDST128   = 4'd8;
  localparam logic [3:0] OP_GOT_LO12  = 4'd9;
  localparam logic [3:0] OP_OTHER     = 4'd10;

  // Status codes (output tuser)
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_NOT_BRANCH    = 4'd1;
  localparam logic [3:0] ST_BR_MISALIGN   = 4'd2;
  localparam logic [3:0] ST_BR_RANGE      = 4'd3;
  localparam logic [3:0] ST_NOT_ADRP      = 4'd4;
  localparam logic [3:0] ST_ADRP_RANGE    = 4'd5;
  localparam logic [3:0] ST_NOT_ADD       = 4'd6;
  localparam logic [3:0] ST_GOT_NOT_LDR   = 4'd7;
  localparam logic [3:0] ST_NOT_LDST      = 4'd8;
  localparam logic [3:0] ST_SCALE_MISMATCH = 4'd9;
  localparam logic [3:0] ST_LO12_MISALIGN = 4'd10;
  localparam logic [3:0] ST_UNSUPPORTED   = 4'd11;

  // Opcode class masks and matches
  localparam logic [31:0] ADRP_KEEP  = 32'h9F00001F;
  localparam logic [31:0] ADRP_MASK  = 32'h9F000000;
  localparam logic [31:0] ADRP_MATCH = 32'h90000000;
  localparam logic [31:0] ADD_MASK   = 32'h7FC00000;
  localparam logic [31:0] ADD_MATCH  = 32'h11000000;
  localparam logic [31:0] B_MASK     = 32'h7C000000;
  localparam logic [31:0] B_MATCH    = 32'h14000000;
  localparam logic [31:0] LDRX_MASK  = 32'hFFC00000;
  localparam logic [31:0] LDRX_MATCH = 32'hF9400000;
  localparam logic [31:0] LDST_MASK  = 32'h3B000000;
  localparam logic [31:0] LDST_MATCH = 32'h39000000;
  localparam logic [31:0] B_KEEP     = 32'hFC000000;

  localparam int PageW = 53;  // (addr >> 12) difference plus a sign bit

  // Stage-2 word: differences and class decode for one relocation
  typedef struct packed {
    logic [3:0]       op;
    logic [31:0]      inst;
    logic [11:0]      lo12;
    logic [63:0]      disp;      // value - place
    logic [PageW-1:0] page;      // (value>>12) - (place>>12), sign-extended
    logic             is_b;
    logic             is_adrp;
    logic             is_add;
    logic             is_ldrx;
    logic             is_ldst;
    logic [2:0]       have_scale;
  } calc_t;

  function automatic logic [2:0] kind_scale(input logic [3:0] op);
    logic [2:0] s;
    case (op)
      OP_LDST8:    s = 3'd0;
      OP_LDST16:   s = 3'd1;
      OP_LDST32:   s = 3'd2;
      OP_LDST64:   s = 3'd3;
      OP_LDST128:  s = 3'd4;
      OP_GOT_LO12: s = 3'd3;
      default:     s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/arp_calc.sv
// Stage 2: address differences and instruction class decode.
`timescale 1ns / 1ps
module arp_calc
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [31:0] in_inst,
  input  logic [63:0] in_place,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output calc_t       out_word
);

  calc_t calc_next;
  logic  valid;

  always_comb begin
    calc_next.op      = in_op;
    calc_next.inst    = in_inst;
    calc_next.lo12    = in_value[11:0];
    calc_next.disp    = in_value - in_place;
    calc_next.page    = {1'b0, in_value[63:12]} - {1'b0, in_place[63:12]};
    calc_next.is_b    = (in_inst & B_MASK) == B_MATCH;
    calc_next.is_adrp = (in_inst & ADRP_MASK) == ADRP_MATCH;
    calc_next.is_add  = (in_inst & ADD_MASK) == ADD_MATCH;
    calc_next.is_ldrx = (in_inst & LDRX_MASK) == LDRX_MATCH;
    calc_next.is_ldst = (in_inst & LDST_MASK) == LDST_MATCH;
    // SIMD with size 0 and opc[1] set is the 128-bit form
    if (in_inst[26] && (in_inst[31:30] == 2'd0) && in_inst[23]) begin
      calc_next.have_scale = 3'd4;
    end else begin
      calc_next.have_scale = {1'b0, in_inst[31:30]};
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= calc_next;
    end
  end

endmodule

### hw/rtl/aarch64_reloc_patch_top.sv
// Top level of the AArch64 relocation patcher: input, decode and result stages.
`timescale 1ns / 1ps
// Patches one AArch64 relocation per word: B/BL 26-bit branch, ADRP page
// (plain and GOT), ADD lo12 and unsigned-offset load/store lo12 (8 to 128
// bits, plus GOT LDR Xt). Each word carries the kind in s_tuser and the
// instruction, place and target in s_tdata; the result word returns the
// patched instruction in m_tdata and a status code in m_tuser. Any nonzero
// status returns the instruction unchanged. The block has no state and no
// configuration. It takes one word per clock unless m_tready holds the
// stages full. A word passes three register stages in order: input
// capture, the 64-bit address subtracts with class decode, and the
// range/scale checks with field insertion into the output register.
// Each stage holds while the one after it is full and stalled, so s_tready
// stays high while any stage has room, even with a result waiting on m_tready.
module aarch64_reloc_patch_top
  import arp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // inst[31:0], place[95:32], value[159:96]
  input  logic [3:0]   s_tuser,   // op[3:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // patched_inst[31:0]
  output logic [3:0]   m_tuser    // status[3:0]
);

  // ---- stage 1: input capture ----
  logic        v1;
  logic        rdy1;
  logic [3:0]  op1;
  logic [31:0] inst1;
  logic [63:0] place1;
  logic [63:0] value1;
  logic        rdy2;

  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      op1    <= s_tuser;
      inst1  <= s_tdata[31:0];
      place1 <= s_tdata[95:32];
      value1 <= s_tdata[159:96];
    end
  end

  // ---- stage 2: subtracts and decode ----
  logic  v2;
  logic  rdy3;
  calc_t c2;

  arp_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (rdy2),
    .in_op     (op1),
    .in_inst   (inst1),
    .in_place  (place1),
    .in_value  (value1),
    .out_valid (v2),
    .out_ready (rdy3),
    .out_word  (c2)
  );

  // ---- stage 3: checks and field insertion ----
  logic [31:0] word_next;
  logic [3:0]  status_next;
  logic [2:0]  want;
  logic [11:0] lo_shift;
  logic        lo_misalign;
  logic        br_in_range;
  logic        pg_in_range;
  logic        v3;
  logic [3:0]  op3;

  assign want = kind_scale(c2.op);
  // branch reach is +/-128 MiB: bits 63:27 must all match the sign
  assign br_in_range = (&c2.disp[63:27]) || !(|c2.disp[63:27]);
  // page reach is +/-4 GiB: bits above 19 must all match the sign
  assign pg_in_range = (&c2.page[PageW-1:20]) || !(|c2.page[PageW-1:20]);

  always_comb begin
    case (want)
      3'd0: begin
        lo_misalign = 1'b0;
        lo_shift    = c2.lo12;
      end
      3'd1: begin
        lo_misalign = c2.lo12[0];
        lo_shift    = {1'b0, c2.lo12[11:1]};
      end
      3'd2: begin
        lo_misalign = |c2.lo12[1:0];
        lo_shift    = {2'b0, c2.lo12[11:2]};
      end
      3'd3: begin
        lo_misalign = |c2.lo12[2:0];
        lo_shift    = {3'b0, c2.lo12[11:3]};
      end
      3'd4: begin
        lo_misalign = |c2.lo12[3:0];
        lo_shift    = {4'b0, c2.lo12[11:4]};
      end
      default: begin
        lo_misalign = 1'b0;
        lo_shift    = c2.lo12;
      end
    endcase
  end

  always_comb begin
    word_next   = c2.inst;
    status_next = ST_OK;
    case (c2.op)
      OP_BRANCH26: begin
        if (!c2.is_b) begin
          status_next = ST_NOT_BRANCH;
        end else if (|c2.disp[1:0]) begin
          status_next = ST_BR_MISALIGN;
        end else if (!br_in_range) begin
          status_next = ST_BR_RANGE;
        end else begin
          word_next = (c2.inst & B_KEEP) | {6'b0, c2.disp[27:2]};
        end
      end
      OP_ADR_PAGE, OP_GOT_PAGE: begin
        if (!c2.is_adrp) begin
          status_next = ST_NOT_ADRP;
        end else if (!pg_in_range) begin
          status_next = ST_ADRP_RANGE;
        end else begin
          // immlo to bits 30:29, immhi to bits 23:5
          word_next = (c2.inst & ADRP_KEEP)
                    | {1'b0, c2.page[1:0], 5'b0, c2.page[20:2], 5'b0};
        end
      end
      OP_ADD_LO12: begin
        if (!c2.is_add) begin
          status_next = ST_NOT_ADD;
        end else begin
          word_next = {c2.inst[31:22], c2.lo12, c2.inst[9:0]};
        end
      end
      OP_LDST8, OP_LDST16, OP_LDST32, OP_LDST64, OP_LDST128, OP_GOT_LO12: begin
        if ((c2.op == OP_GOT_LO12) && !c2.is_ldrx) begin
          status_next = ST_GOT_NOT_LDR;
        end else if (!c2.is_ldst) begin
          status_next = ST_NOT_LDST;
        end else if (c2.have_scale != want) begin
          status_next = ST_SCALE_MISMATCH;
        end else if (lo_misalign) begin
          status_next = ST_LO12_MISALIGN;
        end else begin
          word_next = {c2.inst[31:22], lo_shift, c2.inst[9:0]};
        end
      end
      default: begin
        status_next = ST_UNSUPPORTED;
      end
    endcase
  end

  assign rdy3 = !v3 || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      m_tdata <= word_next;
      m_tuser <= status_next;
      op3     <= c2.op;
    end
  end

  assign m_tvalid = v3;

  // ---- checks ----
  // an empty output stage means every stage upstream can take a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  // supported kinds never report the unsupported code
  a_supported_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (op3 <= OP_GOT_LO12) |-> m_tuser != ST_UNSUPPORTED)
    else $error("supported kind reported as unsupported");

  // ADD lo12 can only pass or fail the class check
  a_add_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (op3 == OP_ADD_LO12) |-> (m_tuser == ST_OK) || (m_tuser == ST_NOT_ADD))
    else $error("bad status for ADD lo12");

  // a word in stage 2 reaches the output once the output stage frees up
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("stage 2 word not advanced");

endmodule

### tb/reloc_patch_check.sv
// Watches both streams of the relocation patcher, predicts each result and compares.
`timescale 1ns / 1ps
module reloc_patch_check
  import arp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,   // inst[31:0], place[95:32], value[159:96]
  input  logic [3:0]   s_tuser,   // op[3:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,   // patched_inst[31:0]
  input  logic [3:0]   m_tuser,   // status[3:0]
  output int           errors,
  output int           outstanding
);

  localparam logic [63:0] BR_BIAS = 64'h0000_0000_0800_0000;
  localparam logic [63:0] BR_SPAN = 64'h0000_0000_1000_0000;
  localparam logic [63:0] PG_BIAS = 64'h0000_0000_0010_0000;
  localparam logic [63:0] PG_SPAN = 64'h0000_0000_0020_0000;

  typedef struct packed {
    logic [31:0] inst;
    logic [3:0]  status;
  } patch_t;

  patch_t pending_patches[$];

  function automatic patch_t patch_reloc(input logic [3:0] op, input logic [31:0] inst,
                                         input logic [63:0] place, input logic [63:0] value);
    patch_t      r;
    logic [63:0] disp;
    logic [63:0] page;
    logic [11:0] lo12;
    int          want;
    int          have;
    r.inst   = inst;
    r.status = ST_OK;
    disp     = value - place;
    page     = (value >> 12) - (place >> 12);
    lo12     = value[11:0];
    case (op)
      OP_BRANCH26: begin
        if ((inst & B_MASK) != B_MATCH) r.status = ST_NOT_BRANCH;
        else if (disp[1:0] != 2'b00) r.status = ST_BR_MISALIGN;
        else if (disp + BR_BIAS >= BR_SPAN) r.status = ST_BR_RANGE;
        else r.inst = (inst & B_KEEP) | {6'b0, disp[27:2]};
      end
      OP_ADR_PAGE, OP_GOT_PAGE: begin
        if ((inst & ADRP_MASK) != ADRP_MATCH) r.status = ST_NOT_ADRP;
        else if (page + PG_BIAS >= PG_SPAN) r.status = ST_ADRP_RANGE;
        else begin
          r.inst        = inst & ADRP_KEEP;
          r.inst[30:29] = page[1:0];
          r.inst[23:5]  = page[20:2];
        end
      end
      OP_ADD_LO12: begin
        if ((inst & ADD_MASK) != ADD_MATCH) r.status = ST_NOT_ADD;
        else r.inst[21:10] = lo12;
      end
      OP_LDST8, OP_LDST16, OP_LDST32, OP_LDST64, OP_LDST128, OP_GOT_LO12: begin
        if (op == OP_LDST128) want = 4;
        else if (op == OP_GOT_LO12) want = 3;
        else want = int'(op - OP_LDST8);
        // SIMD with size 0 and opc high is the 128-bit access
        if ((inst & LDST_MASK) != LDST_MATCH) have = -1;
        else if (inst[26] && inst[31:30] == 2'b00 && inst[23]) have = 4;
        else have = int'(inst[31:30]);
        if (op == OP_GOT_LO12 && (inst & LDRX_MASK) != LDRX_MATCH) r.status = ST_GOT_NOT_LDR;
        else if (have < 0) r.status = ST_NOT_LDST;
        else if (have != want) r.status = ST_SCALE_MISMATCH;
        else if ((lo12 & ((12'd1 << want) - 12'd1)) != 12'd0) r.status = ST_LO12_MISALIGN;
        else r.inst[21:10] = lo12 >> want;
      end
      default: r.status = ST_UNSUPPORTED;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    patch_t exp_word;
    if (rst) begin
      pending_patches.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_patches.size() == 0) begin
          $display("%0t: result word with none expected: inst %h status %0d",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          exp_word = pending_patches.pop_front();
          if (m_tdata !== exp_word.inst) begin
            $display("%0t: patched_inst expected %h actual %h", $time, exp_word.inst, m_tdata);
            errors++;
          end
          if (m_tuser !== exp_word.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_word.status, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_patches.push_back(patch_reloc(s_tuser, s_tdata[31:0], s_tdata[95:32],
                                              s_tdata[159:96]));
    end
    outstanding = pending_patches.size();
  end

endmodule

### tb/testbench.sv
// Top of the relocation patcher bench: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps
module testbench;
  import arp_pkg::*;

  // Highest kind code the 4-bit field can carry; everything from OP_OTHER up
  // is unsupported.
  localparam logic [3:0] OP_TOP = 4'hF;
  localparam int PHASE_WORDS = 375;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;   // inst[31:0], place[95:32], value[159:96]
  logic [3:0]   s_tuser = '0;   // op[3:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;        // patched_inst[31:0]
  logic [3:0]   m_tuser;        // status[3:0]

  int errors;
  int outstanding;

  // Idle odds in percent, changed per phase by the stimulus process.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  aarch64_reloc_patch_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  reloc_patch_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: redrawn every falling edge.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one relocation word, with a random gap first, and hold it until
  // a rising edge sees tready. Returns at the falling edge after acceptance,
  // so tvalid stays high into the next word when no gap is drawn.
  task automatic send_reloc(input logic [3:0] op, input logic [31:0] inst,
                            input logic [63:0] place, input logic [63:0] value);
    logic accepted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {value, place, inst};
    do begin
      @(posedge clk);
      accepted = s_tready;
      @(negedge clk);
    end while (!accepted);
  endtask

  // Mostly well-formed relocations: the instruction matches the class the
  // kind wants and the target sits in range or right at its edges. The rest
  // is noise: random words, far targets, unsupported kinds.
  task automatic send_random_reloc();
    logic [3:0]  op;
    logic [31:0] inst;
    logic [31:0] r;
    logic [63:0] place;
    logic [63:0] value;
    logic [63:0] delta;
    int          want;
    if ($urandom_range(9) == 0) op = 4'($urandom_range(OP_TOP, OP_OTHER));
    else op = 4'($urandom_range(OP_GOT_LO12, OP_BRANCH26));
    place = {$urandom, $urandom};
    if ($urandom_range(15) == 0) place = $urandom_range(1) ? '1 : '0;
    value = {$urandom, $urandom};
    inst  = $urandom;
    r     = $urandom;
    case (op)
      OP_BRANCH26: begin
        inst = ($urandom & ~B_MASK) | B_MATCH;
        case ($urandom_range(9))
          0: delta = 64'h0000_0000_07FF_FFFC;   // last reachable forward
          1: delta = 64'h0000_0000_0800_0000;   // one word too far forward
          2: delta = 64'hFFFF_FFFF_F800_0000;   // furthest backward
          3: delta = 64'hFFFF_FFFF_F7FF_FFFC;   // one word too far back
          4: delta = value;
          5: delta = {{36{r[27]}}, r[27:0]};    // may be misaligned
          default: delta = {{36{r[27]}}, r[27:2], 2'b00};
        endcase
        value = place + delta;
      end
      OP_ADR_PAGE, OP_GOT_PAGE: begin
        inst = ($urandom & ~ADRP_MASK) | ADRP_MATCH;
        case ($urandom_range(9))
          0: delta = 64'h0000_0000_000F_FFFF;
          1: delta = 64'h0000_0000_0010_0000;
          2: delta = 64'hFFFF_FFFF_FFF0_0000;
          3: delta = 64'hFFFF_FFFF_FFEF_FFFF;
          4: delta = value;
          default: delta = {{43{r[20]}}, r[20:0]};
        endcase
        // page delta in pages, random offset within the target page
        value = {place[63:12] + delta[51:0], value[11:0]};
      end
      OP_ADD_LO12: inst = ($urandom & ~ADD_MASK) | ADD_MATCH;
      OP_GOT_LO12: begin
        inst = ($urandom & ~LDRX_MASK) | LDRX_MATCH;
        if ($urandom_range(3) != 0) value[2:0] = 3'b000;
      end
      OP_LDST8, OP_LDST16, OP_LDST32, OP_LDST64, OP_LDST128: begin
        want = int'(op - OP_LDST8);
        inst = ($urandom & ~LDST_MASK) | LDST_MATCH;
        if ($urandom_range(3) != 0) begin
          if (op == OP_LDST128) begin
            inst[31:30] = 2'b00;
            inst[26]    = 1'b1;
            inst[23]    = 1'b1;
          end else begin
            inst[31:30] = want[1:0];
          end
        end
        if ($urandom_range(3) != 0) value = value & ~((64'd1 << want) - 64'd1);
      end
      default: ;
    endcase
    if ($urandom_range(6) == 0) inst = $urandom;
    send_reloc(op, inst, place, value);
  endtask

  // Stop sending and wait for every predicted result to come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, back to back.
    // branch: in range, both range edges, misaligned, wrong class, wraparound
    send_reloc(OP_BRANCH26, 32'h1400_0000, 64'h0000_0000_0040_0000, 64'h0000_0000_0040_1000);
    send_reloc(OP_BRANCH26, 32'h97FF_FFFF, 64'h0000_0000_1000_0000, 64'h0000_0000_17FF_FFFC);
    send_reloc(OP_BRANCH26, 32'h9400_0000, 64'h0000_0000_1000_0000, 64'h0000_0000_1800_0000);
    send_reloc(OP_BRANCH26, 32'h1400_0000, 64'h0000_0000_1000_0000, 64'h0000_0000_0800_0000);
    send_reloc(OP_BRANCH26, 32'h1400_0000, 64'h0000_0000_1000_0000, 64'h0000_0000_07FF_FFFC);
    send_reloc(OP_BRANCH26, 32'h1400_0000, 64'h0, 64'h2);
    send_reloc(OP_BRANCH26, 32'hD503_201F, 64'h0, 64'h4);
    send_reloc(OP_BRANCH26, 32'h17FF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC, 64'h0);
    // page kinds: both edges of the page window, one past each, wrong class
    send_reloc(OP_ADR_PAGE, 32'h9000_0010, 64'h0, 64'h0000_0000_FFFF_FFFF);
    send_reloc(OP_ADR_PAGE, 32'h9000_0010, 64'h0, 64'h0000_0001_0000_0000);
    send_reloc(OP_ADR_PAGE, 32'hF000_001F, 64'h0000_0001_0000_0FFF, 64'h0);
    send_reloc(OP_ADR_PAGE, 32'h9000_0000, 64'h0000_0001_0000_1000, 64'h0);
    send_reloc(OP_GOT_PAGE, 32'h9000_0001, 64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_0000_5123);
    send_reloc(OP_GOT_PAGE, 32'h1000_0000, 64'h0, 64'h0);
    // add lo12: all-ones target, SUB is rejected
    send_reloc(OP_ADD_LO12, 32'h9100_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reloc(OP_ADD_LO12, 32'hD100_0000, 64'h0, 64'h123);
    // load/store lo12: each size, Q form, scale mismatch, misaligned, not a load
    send_reloc(OP_LDST8,   32'h3940_0000, 64'h0, 64'h0FFF);
    send_reloc(OP_LDST16,  32'h7940_0000, 64'h0, 64'h0FFE);
    send_reloc(OP_LDST32,  32'hB940_0000, 64'h0, 64'h0FFD);
    send_reloc(OP_LDST64,  32'hB940_0000, 64'h0, 64'h0008);
    send_reloc(OP_LDST64,  32'hF900_0000, 64'h0, 64'h0FF8);
    send_reloc(OP_LDST128, 32'h3DC0_0000, 64'h0, 64'h0FF0);
    send_reloc(OP_LDST8,   32'h0000_0000, 64'h0, 64'h0);
    // GOT lo12: the LDR Xt check wins over the scale check
    send_reloc(OP_GOT_LO12, 32'hF940_0000, 64'h0, 64'h0FF8);
    send_reloc(OP_GOT_LO12, 32'hB940_0000, 64'h0, 64'h0);
    send_reloc(OP_GOT_LO12, 32'hF940_0000, 64'h0, 64'h0004);
    // unsupported kinds
    send_reloc(OP_OTHER, 32'h1400_0000, 64'h0, 64'h0);
    send_reloc(OP_TOP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random phases: free flowing, slow sender, slow receiver, both a bit idle.
    // Each phase ends with the sender holding off until all results are back.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      repeat (PHASE_WORDS) send_random_reloc();
      drain_results();
    end

    // Let a few pipeline depths pass so a stray result would still be caught.
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
